>>> rtl/bsr_pkg.sv
// Shared types and constants for the byte stream reassembler.
// No dependencies; every other file imports this package.
`default_nettype none

package bsr_pkg;

  localparam int DEFAULT_CAPACITY = 1024;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_END  = 2'd1,
    CMD_POP  = 2'd2
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_STORED       = 3'd0,
    ST_DUPLICATE    = 3'd1,
    ST_OUTSIDE      = 3'd2,
    ST_CONFLICT     = 3'd3,
    ST_END_MISMATCH = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] position;
    logic [7:0]  data_byte;
    logic        ends_after;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        stream_ended;
    logic [10:0] pending_count;
    logic [10:0] readable_count;
    logic [31:0] next_needed;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic calc;
    logic decide;
    logic asm_rd;
    logic asm_step;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clear_last;
    logic go_assemble;
    logic asm_more;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/bsr_dp.sv
// Datapath of the byte stream reassembler: ring and held-flag memories,
// stream pointers, counters and the result register. Uses bsr_pkg.
`default_nettype none

module bsr_dp import bsr_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire dp_cmd_t   cmd,
  output dp_stat_t       stat,
  input  wire in_item_t  in_item,
  output out_item_t      out_item
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [SW:0]   CAP_W     = (SW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
  localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);

  logic [7:0] ring_mem [CAPACITY];
  logic       held_mem [CAPACITY];
  logic [7:0] ring_q;
  logic       held_q;

  in_item_t    item_r;
  logic [31:0] offset_r;
  logic [31:0] ann_r;
  logic        in_win_r;
  logic [SW-1:0] slot_r;
  status_t     status_r;
  logic        rvalid_r;
  logic [7:0]  rbyte_r;
  out_item_t   out_item_r;

  logic [31:0]   asm_r, asm_nxt;
  logic [SW-1:0] asm_slot_r, asm_slot_nxt;
  logic          end_known_r, end_known_nxt;
  logic [31:0]   end_point_r, end_point_nxt;
  logic [CW-1:0] held_cnt_r, held_cnt_nxt;
  logic [CW-1:0] buf_cnt_r, buf_cnt_nxt;
  logic [SW-1:0] clr_idx_r, clr_idx_nxt;

  logic [CW-1:0] free_room;
  logic          in_win;
  logic [SW:0]   push_sum, pop_sum;
  logic [SW-1:0] push_slot, pop_slot, rd_slot, held_ra;
  logic          is_push, is_end, is_pop;
  logic          announce, mismatch, record_end, store, pop_ok, asm_go;
  status_t       status_nxt;
  logic          held_we, held_wd;
  logic [SW-1:0] held_wa;

  // Slot arithmetic works from the slot of the assembled point, so no modulo
  // of a position is ever needed: every offset used is below the capacity.
  always_comb begin
    free_room = CAP_C - buf_cnt_r;
    in_win    = offset_r < 32'(free_room);
    push_sum  = {1'b0, asm_slot_r} + {1'b0, offset_r[SW-1:0]};
    push_slot = (push_sum >= CAP_W) ? SW'(push_sum - CAP_W) : push_sum[SW-1:0];
    pop_sum   = {1'b0, asm_slot_r} + CAP_W - (SW + 1)'(buf_cnt_r);
    pop_slot  = (pop_sum >= CAP_W) ? SW'(pop_sum - CAP_W) : pop_sum[SW-1:0];
    rd_slot   = (item_r.cmd == CMD_POP) ? pop_slot : push_slot;
    held_ra   = cmd.asm_rd ? asm_slot_r : rd_slot;
  end

  always_comb begin
    is_push    = item_r.cmd == CMD_PUSH;
    is_end     = item_r.cmd == CMD_END;
    is_pop     = item_r.cmd == CMD_POP;
    announce   = is_end || (is_push && item_r.ends_after);
    mismatch   = announce && end_known_r && (end_point_r != ann_r);
    record_end = announce && !end_known_r;
    store      = is_push && !mismatch && in_win_r && !held_q;
    pop_ok     = is_pop && (buf_cnt_r != '0);
    asm_go     = held_q && !(end_known_r && !(asm_r < end_point_r));

    priority if (mismatch) begin
      status_nxt = ST_END_MISMATCH;
    end else if (is_push && !in_win_r) begin
      status_nxt = ST_OUTSIDE;
    end else if (is_push && held_q) begin
      status_nxt = (ring_q == item_r.data_byte) ? ST_DUPLICATE : ST_CONFLICT;
    end else begin
      status_nxt = ST_STORED;
    end
  end

  assign stat.clear_last  = clr_idx_r == LAST_SLOT;
  // A fresh byte at the assembled point is the only thing that can extend
  // the contiguous run.
  assign stat.go_assemble = store && (slot_r == asm_slot_r);
  assign stat.asm_more    = asm_go;

  always_comb begin
    asm_nxt       = asm_r;
    asm_slot_nxt  = asm_slot_r;
    end_known_nxt = end_known_r;
    end_point_nxt = end_point_r;
    held_cnt_nxt  = held_cnt_r;
    buf_cnt_nxt   = buf_cnt_r;
    clr_idx_nxt   = clr_idx_r;
    held_we       = 1'b0;
    held_wa       = clr_idx_r;
    held_wd       = 1'b0;
    if (cmd.clear_step) begin
      held_we     = 1'b1;
      clr_idx_nxt = clr_idx_r + SW'(1);
    end
    if (cmd.decide) begin
      if (record_end) begin
        end_known_nxt = 1'b1;
        end_point_nxt = ann_r;
      end
      if (store) begin
        held_we      = 1'b1;
        held_wa      = slot_r;
        held_wd      = 1'b1;
        held_cnt_nxt = held_cnt_r + CW'(1);
      end
      if (pop_ok) begin
        buf_cnt_nxt = buf_cnt_r - CW'(1);
      end
    end
    if (cmd.asm_step && asm_go) begin
      held_we      = 1'b1;
      held_wa      = asm_slot_r;
      asm_nxt      = asm_r + 32'd1;
      asm_slot_nxt = (asm_slot_r == LAST_SLOT) ? '0 : asm_slot_r + SW'(1);
      buf_cnt_nxt  = buf_cnt_r + CW'(1);
      if (held_cnt_r != '0) begin
        held_cnt_nxt = held_cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_r       <= '0;
      asm_slot_r  <= '0;
      end_known_r <= 1'b0;
      end_point_r <= '0;
      held_cnt_r  <= '0;
      buf_cnt_r   <= '0;
      clr_idx_r   <= '0;
    end else begin
      asm_r       <= asm_nxt;
      asm_slot_r  <= asm_slot_nxt;
      end_known_r <= end_known_nxt;
      end_point_r <= end_point_nxt;
      held_cnt_r  <= held_cnt_nxt;
      buf_cnt_r   <= buf_cnt_nxt;
      clr_idx_r   <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (held_we) begin
      held_mem[held_wa] <= held_wd;
    end
    if (cmd.calc || cmd.asm_rd) begin
      held_q <= held_mem[held_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && store) begin
      ring_mem[slot_r] <= item_r.data_byte;
    end
    if (cmd.calc) begin
      ring_q <= ring_mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r   <= in_item;
      offset_r <= in_item.position - asm_r;
    end
    if (cmd.calc) begin
      in_win_r <= in_win;
      slot_r   <= rd_slot;
      ann_r    <= is_push ? item_r.position + 32'd1 : item_r.position;
    end
    if (cmd.decide) begin
      status_r <= status_nxt;
      rvalid_r <= pop_ok;
      rbyte_r  <= pop_ok ? ring_q : 8'd0;
    end
    if (cmd.load_out) begin
      out_item_r.status         <= status_r;
      out_item_r.read_valid     <= rvalid_r;
      out_item_r.read_byte      <= rbyte_r;
      out_item_r.stream_ended   <= end_known_r && (asm_r == end_point_r);
      out_item_r.pending_count  <= 11'(held_cnt_r);
      out_item_r.readable_count <= 11'(buf_cnt_r);
      out_item_r.next_needed    <= asm_r;
    end
  end

  assign out_item = out_item_r;

endmodule

`default_nettype wire

>>> rtl/bsr_ctrl.sv
// Controller of the byte stream reassembler: sequences the clearing pass,
// each beat's lookup and update, assembly and the output handshake. Uses bsr_pkg.
`default_nettype none

module bsr_ctrl import bsr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_CALC   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_ASM_RD = 7'b0010000,
    S_ASM_CK = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.go_assemble ? S_ASM_RD : S_FIN;
      end
      S_ASM_RD: begin
        cmd.asm_rd = 1'b1;
        state_nxt  = S_ASM_CK;
      end
      S_ASM_CK: begin
        cmd.asm_step = 1'b1;
        state_nxt    = stat.asm_more ? S_ASM_RD : S_FIN;
      end
      S_FIN: begin
        // The result waits here until the output register is free.
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/byte_stream_reassembler.sv
// Top level of the byte stream reassembler: controller plus datapath.
// Depends on bsr_pkg, bsr_ctrl and bsr_dp.
`default_nettype none

// Each beat carries one pushed byte, an end marker or a pop, and yields one
// result beat with a status code and the stream counters after the beat.
// After reset the block sweeps its held-flag memory and holds in_stall high
// meanwhile. A beat then goes through accept, slot address and memory read,
// decision and write, and output load. A beat that stores a byte at the
// assembled point adds a read step and a check step for every byte that
// assembly moves on and for the check that ends the run, since each step
// reads and then clears one held flag through the single memory port.
// Other beats skip assembly.
// The result sits in an output register, so the next beat is accepted while
// it waits; that beat cannot complete until the register is taken.
module byte_stream_reassembler import bsr_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  bsr_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

>>> rtl/bsr_checker.sv
// Port-level checks for the byte stream reassembler and their binding.
// Depends on bsr_pkg and byte_stream_reassembler.
`default_nettype none

module bsr_checker import bsr_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // The clearing pass follows every reset, so no beat is taken straight after.
  a_stall_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input accepted straight after reset");

  // One beat is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted while one is in progress");

  a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.read_valid |-> out_item.status == ST_STORED)
    else $error("returned byte with a non-zero status");

  a_no_stray_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.read_valid |-> out_item.read_byte == 8'd0)
    else $error("read byte set without a returned byte");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result beat changed");

endmodule

bind byte_stream_reassembler bsr_checker u_bsr_checker (.*);

`default_nettype wire

>>> sim/bsr_checker.sv
// Result checker for the byte stream reassembler: follows both channels, predicts every
// result beat from the accepted input beats and compares them field by field.
// Depends on bsr_pkg only.
module bsr_scoreboard import bsr_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_item_t  in_item,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_item_t out_item,
  output int             fail_count,
  output int             results_due
);

  // Predicted stream state: ring contents, held flags and the counters.
  logic [7:0]  ring_byte [CAPACITY];
  bit          ring_held [CAPACITY];
  logic [31:0] asm_point;
  logic [31:0] end_point;
  bit          end_seen;
  int unsigned held_total;
  int unsigned ready_total;
  out_item_t   status_q [$];

  // The first announced end is kept; any later, different one is refused.
  function automatic bit note_end(input logic [31:0] pos);
    if (end_seen) begin
      return end_point == pos;
    end
    end_seen  = 1'b1;
    end_point = pos;
    return 1'b1;
  endfunction

  function automatic out_item_t step_stream(input in_item_t it);
    out_item_t   res;
    status_t     st;
    int unsigned room;
    logic [31:0] offs;
    int unsigned slot;
    logic [31:0] rd_pos;
    res = '0;
    st  = ST_STORED;
    case (it.cmd)
      CMD_PUSH: begin
        if (it.ends_after && !note_end(it.position + 32'd1)) begin
          st = ST_END_MISMATCH;
        end else begin
          room = (ready_total >= CAPACITY) ? 0 : CAPACITY - ready_total;
          offs = it.position - asm_point;
          slot = it.position % CAPACITY;
          if (offs >= room) begin
            st = ST_OUTSIDE;
          end else if (ring_held[slot]) begin
            st = (ring_byte[slot] == it.data_byte) ? ST_DUPLICATE : ST_CONFLICT;
          end else begin
            ring_byte[slot] = it.data_byte;
            ring_held[slot] = 1'b1;
            held_total++;
          end
        end
      end
      CMD_END: begin
        if (!note_end(it.position)) begin
          st = ST_END_MISMATCH;
        end
      end
      CMD_POP: begin
        if (ready_total > 0) begin
          rd_pos         = asm_point - ready_total;
          res.read_valid = 1'b1;
          res.read_byte  = ring_byte[rd_pos % CAPACITY];
          ready_total--;
        end
      end
      default: ;
    endcase
    // Move the contiguous run of held bytes into the readable part, never past a known end.
    while (!(end_seen && asm_point >= end_point) && ring_held[asm_point % CAPACITY]) begin
      ring_held[asm_point % CAPACITY] = 1'b0;
      if (held_total > 0) begin
        held_total--;
      end
      ready_total++;
      asm_point++;
    end
    res.status         = st;
    res.stream_ended   = end_seen && (asm_point == end_point);
    res.pending_count  = 11'(held_total);
    res.readable_count = 11'(ready_total);
    res.next_needed    = asm_point;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    int        k;
    if (!rst_n) begin
      for (k = 0; k < CAPACITY; k++) begin
        ring_held[k] = 1'b0;
      end
      asm_point   = '0;
      end_point   = '0;
      end_seen    = 1'b0;
      held_total  = 0;
      ready_total = 0;
      status_q.delete();
      results_due <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result beat with none expected: %h", $realtime, out_item);
          end
        end else begin
          want = status_q.pop_front();
          check_field("status", 32'(out_item.status), 32'(want.status));
          check_field("read_valid", 32'(out_item.read_valid), 32'(want.read_valid));
          check_field("read_byte", 32'(out_item.read_byte), 32'(want.read_byte));
          check_field("stream_ended", 32'(out_item.stream_ended),
                      32'(want.stream_ended));
          check_field("pending_count", 32'(out_item.pending_count),
                      32'(want.pending_count));
          check_field("readable_count", 32'(out_item.readable_count),
                      32'(want.readable_count));
          check_field("next_needed", out_item.next_needed, want.next_needed);
        end
      end
      if (in_valid && !in_stall) begin
        status_q = {status_q, step_stream(in_item)};
      end
      results_due <= status_q.size();
    end
  end

endmodule

>>> sim/tb_top.sv
// Top of the reassembler testbench: clock, reset, beat stimulus and the verdict.
// Depends on bsr_pkg, byte_stream_reassembler and bsr_scoreboard.
module tb_top;
  import bsr_pkg::*;

  localparam int         CAPACITY      = DEFAULT_CAPACITY;
  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         PHASE_ITEMS   = 250;
  localparam int         TAIL_ITEMS    = 150;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         RUN_LIMIT     = 5_000_000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  int          fail_count;
  int          results_due;

  int          send_idle_pct = 28;
  int          recv_idle_pct = 86;
  int          items_sent    = 0;
  logic [31:0] seen_next     = '0;
  int unsigned seen_ready    = 0;
  logic [31:0] end_mark      = '0;

  byte_stream_reassembler #(.CAPACITY(CAPACITY)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  bsr_scoreboard #(.CAPACITY(CAPACITY)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .results_due(results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // The stimulus steers its segments by the last assembly point that came back.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      seen_next  <= out_item.next_needed;
      seen_ready <= 32'(out_item.readable_count);
    end
  end

  // Every position has a fixed byte, so retransmitted bytes normally agree.
  function automatic logic [7:0] stream_byte(input logic [31:0] pos);
    return pos[7:0] ^ pos[15:8] ^ pos[23:16] ^ 8'hA5;
  endfunction

  task automatic send_beat(input logic [1:0] cmd, input logic [31:0] pos,
                           input logic [7:0] data, input logic ends);
    in_item_t it;
    it.cmd        = cmd;
    it.position   = pos;
    it.data_byte  = data;
    it.ends_after = ends;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic pop_beat();
    send_beat(CMD_POP, $urandom(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_due == 0);
    @(posedge clk);
  endtask

  task automatic send_segment(input logic [31:0] start, input int len, input bit after_end);
    bit          downward;
    int          i;
    logic [31:0] pos;
    logic [7:0]  value;
    downward = ($urandom_range(0, 9) < 3);
    for (i = 0; i < len; i++) begin
      pos   = downward ? start + len - 1 - i : start + i;
      value = stream_byte(pos);
      if ($urandom_range(0, 99) < 6) begin
        value = value ^ (8'h01 << $urandom_range(0, 7));
      end
      send_beat(CMD_PUSH, pos, value, after_end && ($urandom_range(0, 3) == 0));
    end
  endtask

  // Mostly segments near the assembly point, with pops, stray bytes and unused commands.
  // End markers, and end flags on pushed bytes, only appear once the end is already fixed.
  task automatic random_traffic(input int n_items, input bit after_end);
    int          stop_at;
    int unsigned pick;
    int          len;
    logic [31:0] start;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (seen_ready > 400 && pick < 50) begin
        pick = 60;
      end
      if (pick < 55) begin
        len = $urandom_range(1, 12);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: start = seen_next;
          4, 5, 6:    start = seen_next + $urandom_range(1, 48);
          7:          start = seen_next - $urandom_range(1, 32);
          8:          start = seen_next + CAPACITY - seen_ready - $urandom_range(0, 8);
          default:    start = $urandom();
        endcase
        send_segment(start, len, after_end);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) pop_beat();
      end else if (pick < 93) begin
        send_beat(CMD_PUSH, $urandom(), 8'($urandom_range(0, 255)),
                  after_end && $urandom_range(0, 1));
      end else if (pick < 96) begin
        send_beat(CMD_UNUSED, $urandom(), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else if (after_end) begin
        send_beat(CMD_END, $urandom_range(0, 1) ? end_mark : $urandom(),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        pop_beat();
      end
    end
  endtask

  task automatic directed_opening();
    int i;
    send_beat(CMD_PUSH, 32'd0, 8'h00, 1'b0);
    send_beat(CMD_PUSH, 32'd0, 8'h00, 1'b0);           // already assembled
    send_beat(CMD_PUSH, 32'd5, 8'hFF, 1'b0);
    send_beat(CMD_PUSH, 32'd5, 8'hFF, 1'b0);           // same byte again
    send_beat(CMD_PUSH, 32'd5, 8'h3C, 1'b0);           // different byte in a held slot
    send_beat(CMD_POP, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_beat(CMD_POP, 32'd0, 8'h00, 1'b0);            // nothing left to read
    send_beat(CMD_PUSH, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    send_beat(CMD_PUSH, CAPACITY, stream_byte(CAPACITY), 1'b0);        // last slot in window
    send_beat(CMD_PUSH, CAPACITY + 1, stream_byte(CAPACITY + 1), 1'b0); // first slot beyond
    send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    for (i = 1; i < 5; i++) begin
      send_beat(CMD_PUSH, i, stream_byte(i), 1'b0);
    end
    send_beat(CMD_POP, 32'h5555_AAAA, 8'h5A, 1'b0);
    send_beat(CMD_PUSH, 32'h8000_0000, 8'h81, 1'b0);
  endtask

  // In-order bytes with no pops until the readable part takes the whole ring.
  task automatic fill_ring();
    logic [31:0] front;
    int          guard;
    front = seen_next;
    guard = 0;
    while (seen_ready < CAPACITY && guard < CAPACITY + 200) begin
      if (seen_next > front) begin
        front = seen_next;
      end
      send_beat(CMD_PUSH, front, stream_byte(front), 1'b0);
      front++;
      guard++;
    end
    repeat (12) begin
      send_beat(CMD_PUSH, seen_next + $urandom_range(0, 3), 8'($urandom_range(0, 255)), 1'b0);
    end
    repeat (200) pop_beat();
  endtask

  // Fixes the end a few bytes ahead, then runs assembly up to it and pushes bytes past it.
  task automatic close_stream();
    logic [31:0] base;
    int          i;
    base     = seen_next;
    end_mark = base + 6;
    send_beat(CMD_END, end_mark, 8'h00, 1'b0);
    send_beat(CMD_PUSH, end_mark - 1, stream_byte(end_mark - 1), 1'b1); // agrees with the end
    send_beat(CMD_PUSH, end_mark, stream_byte(end_mark), 1'b1);          // tries to move the end
    send_beat(CMD_END, end_mark + 3, 8'h00, 1'b0);
    for (i = 0; i < 5; i++) begin
      send_beat(CMD_PUSH, base + i, stream_byte(base + i), 1'b0);
    end
    send_beat(CMD_PUSH, end_mark, stream_byte(end_mark), 1'b0);          // beyond the end
    send_beat(CMD_PUSH, end_mark + 2, stream_byte(end_mark + 2), 1'b0);
    send_beat(CMD_PUSH, end_mark, stream_byte(end_mark), 1'b0);
    send_beat(CMD_END, end_mark, 8'hFF, 1'b1);
    send_beat(CMD_PUSH, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    repeat (3) pop_beat();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    directed_opening();
    random_traffic(PHASE_ITEMS, 1'b0);
    settle();
    send_idle_pct = 86;
    recv_idle_pct = 28;
    random_traffic(PHASE_ITEMS, 1'b0);
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_ring();
    settle();
    close_stream();
    random_traffic(TAIL_ITEMS, 1'b1);
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

endmodule
